@@ rtl/bcc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bcc_pkg
// Shared widths, reciprocal constants, types and digit helpers for the
// BCD calendar codec.
// ============================================================================
package bcc_pkg;

    localparam int unsigned MILLIS_W = 27;
    localparam int unsigned TWORD_W  = 22;
    localparam int unsigned DWORD_W  = 24;
    localparam int unsigned PRESC_W  = 16;
    localparam int unsigned SSR_W    = 16;

    localparam int unsigned SEC_W  = 18;
    localparam int unsigned MIN_W  = 12;
    localparam int unsigned HOUR_W = 6;

    // exact floor division by reciprocal multiply
    localparam int unsigned        RECIP_1000_SH = 37;
    localparam logic [27:0]        RECIP_1000    = 28'd137438954;
    localparam int unsigned        RECIP_60S_SH  = 24;
    localparam logic [18:0]        RECIP_60S     = 19'd279621;
    localparam int unsigned        RECIP_60M_SH  = 18;
    localparam logic [12:0]        RECIP_60M     = 13'd4370;

    localparam int unsigned DIV_STEPS  = 6;
    localparam int unsigned DIV_STAGES = 3;
    localparam int unsigned Q_W        = DIV_STEPS * DIV_STAGES;

    localparam int unsigned PIPE_DEPTH = 5;

    localparam logic [PRESC_W-1:0]  PRESC_RESET  = 16'd256;
    localparam logic [10:0]         SUBSEC_LIMIT = 11'd1000;
    localparam logic [MILLIS_W-1:0] MILLIS_MAX   = '1;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic vld;
        t_cmd cmd;
    } t_ctl;

    typedef struct packed {
        logic [6:0]         year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [2:0]         weekday;
        logic [DWORD_W-1:0] word;
    } t_date_raw;

    typedef struct packed {
        logic [PRESC_W-1:0] rem;
        logic [Q_W-1:0]     q;
    } t_div;

    // value below 64 to {tens, units}
    function automatic logic [7:0] split_dec6(input logic [5:0] x);
        logic [12:0] prod;
        logic [5:0]  tens;
        logic [5:0]  units;
        prod  = 13'(x) * 13'd103;
        tens  = 6'(prod[12:10]);
        units = x - 6'(tens * 6'd10);
        return {4'(tens), units[3:0]};
    endfunction

    function automatic logic [DWORD_W-1:0] enc_date(
        input logic [6:0] year,
        input logic [3:0] month,
        input logic [4:0] day,
        input logic [2:0] weekday
    );
        logic [14:0] prod;
        logic [3:0]  yt;
        logic [3:0]  yu;
        logic        mt;
        logic [3:0]  mu;
        logic [1:0]  dt;
        logic [4:0]  du;
        prod = 15'(year) * 15'd205;
        yt   = prod[14:11];
        yu   = 4'(year - 7'(yt) * 7'd10);
        if (yt >= 4'd10) begin
            yt = yt - 4'd10;
        end
        mt = (month >= 4'd10);
        mu = mt ? month - 4'd10 : month;
        priority if (day >= 5'd30) begin
            dt = 2'd3;
        end else if (day >= 5'd20) begin
            dt = 2'd2;
        end else if (day >= 5'd10) begin
            dt = 2'd1;
        end else begin
            dt = 2'd0;
        end
        du = day - 5'(dt) * 5'd10;
        return {yt, yu, weekday, mt, mu, 2'b00, dt, du[3:0]};
    endfunction

endpackage

@@ rtl/bcc_div_stage.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bcc_div_stage
// One registered slice of the restoring divider: a few quotient bits per
// stage, partial remainder and quotient carried to the next slice.
// ============================================================================
module bcc_div_stage import bcc_pkg::*; (
    input  logic                 i_clk,
    input  logic [PRESC_W-1:0]   i_divisor,
    input  logic [PRESC_W-1:0]   i_rem,
    input  logic [Q_W-1:0]       i_q,
    input  logic [DIV_STEPS-1:0] i_bits,
    output logic [PRESC_W-1:0]   o_rem,
    output logic [Q_W-1:0]       o_q
);

    t_div r_res;
    t_div n_res;

    always_comb begin
        logic [PRESC_W-1:0]   rem;
        logic [PRESC_W:0]     trial;
        logic [DIV_STEPS-1:0] qb;
        rem = i_rem;
        qb  = '0;
        for (int k = DIV_STEPS - 1; k >= 0; k--) begin
            trial = {rem, i_bits[k]};
            if (trial >= {1'b0, i_divisor}) begin
                rem   = PRESC_W'(trial - {1'b0, i_divisor});
                qb[k] = 1'b1;
            end else begin
                rem = trial[PRESC_W-1:0];
            end
        end
        n_res.rem = rem;
        n_res.q   = {i_q[Q_W-DIV_STEPS-1:0], qb};
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_rem = r_res.rem;
    assign o_q   = r_res.q;

endmodule

@@ rtl/bcc_time_enc.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bcc_time_enc
// Encode pipeline: milliseconds of day to packed BCD time word over five
// register stages of constant division and digit split.
// ============================================================================
module bcc_time_enc import bcc_pkg::*; (
    input  logic                i_clk,
    input  logic [MILLIS_W-1:0] i_millis,
    output logic [TWORD_W-1:0]  o_time_word
);

    logic [54:0] prod1;
    logic [36:0] prod2;
    logic [24:0] prod3;
    logic [7:0]  min_bcd;

    logic [SEC_W-1:0]   r1_n;
    logic [SEC_W-1:0]   r2_n;
    logic [MIN_W-1:0]   r2_mtot;
    logic [5:0]         r3_sec;
    logic [HOUR_W-1:0]  r3_htot;
    logic [MIN_W-1:0]   r3_mtot;
    logic [5:0]         r4_min;
    logic [7:0]         r4_sec_bcd;
    logic [7:0]         r4_hr_bcd;
    logic [TWORD_W-1:0] r5_word;

    assign prod1   = 55'(i_millis) * 55'(RECIP_1000);
    assign prod2   = 37'(r1_n) * 37'(RECIP_60S);
    assign prod3   = 25'(r2_mtot) * 25'(RECIP_60M);
    assign min_bcd = split_dec6(r4_min);

    always_ff @(posedge i_clk) begin
        r1_n       <= prod1[RECIP_1000_SH +: SEC_W];
        r2_n       <= r1_n;
        r2_mtot    <= prod2[RECIP_60S_SH +: MIN_W];
        r3_sec     <= 6'(r2_n - SEC_W'(r2_mtot) * 18'd60);
        r3_htot    <= prod3[RECIP_60M_SH +: HOUR_W];
        r3_mtot    <= r2_mtot;
        r4_min     <= 6'(r3_mtot - MIN_W'(r3_htot) * 12'd60);
        r4_sec_bcd <= split_dec6(r3_sec);
        r4_hr_bcd  <= split_dec6(r3_htot);
        r5_word    <= {r4_hr_bcd[5:4], r4_hr_bcd[3:0], 1'b0,
                       min_bcd[6:4], min_bcd[3:0], 1'b0,
                       r4_sec_bcd[6:4], r4_sec_bcd[3:0]};
    end

    assign o_time_word = r5_word;

endmodule

@@ rtl/bcc_time_dec.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bcc_time_dec
// Decode pipeline: BCD time word weighted back to milliseconds, plus the
// subsecond count scaled through a pipelined division by the prescaler.
// ============================================================================
module bcc_time_dec import bcc_pkg::*; (
    input  logic                i_clk,
    input  logic [TWORD_W-1:0]  i_time_word,
    input  logic [SSR_W-1:0]    i_ssr,
    input  logic [PRESC_W-1:0]  i_presc,
    output logic [MILLIS_W-1:0] o_millis
);

    logic [PRESC_W-1:0]   w_rem  [DIV_STAGES+1];
    logic [Q_W-1:0]       w_q    [DIV_STAGES+1];
    logic [DIV_STEPS-1:0] w_bits [DIV_STAGES];

    logic [5:0]  n1_h;
    logic [6:0]  n1_m;
    logic [6:0]  n1_s;
    logic        n1_sat;
    logic [27:0] sub_prod;
    logic [11:0] sub_raw;
    logic [10:0] n4_sub;
    logic [27:0] sum;

    logic [5:0]          r1_h;
    logic [6:0]          r1_m;
    logic [6:0]          r1_s;
    logic                r1_sat;
    logic [11:0]         r2_t1;
    logic [6:0]          r2_s;
    logic                r2_sat;
    logic [17:0]         r3_t2;
    logic                r3_sat;
    logic [27:0]         r4_t3;
    logic [10:0]         r4_sub;
    logic [MILLIS_W-1:0] r5_millis;

    // quotient below 2^17 unless the count reaches twice the prescaler
    assign w_rem[0] = {2'b00, i_ssr[SSR_W-1:2]};
    assign w_q[0]   = '0;

    always_comb begin
        for (int g = 0; g < DIV_STAGES; g++) begin
            w_bits[g] = '0;
        end
        w_bits[0] = {i_ssr[1:0], {(DIV_STEPS-2){1'b0}}};
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        bcc_div_stage u_div_stage (
            .i_clk     (i_clk),
            .i_divisor (i_presc),
            .i_rem     (w_rem[g]),
            .i_q       (w_q[g]),
            .i_bits    (w_bits[g]),
            .o_rem     (w_rem[g+1]),
            .o_q       (w_q[g+1])
        );
    end

    assign n1_h   = 6'(i_time_word[21:20]) * 6'd10 + 6'(i_time_word[19:16]);
    assign n1_m   = 7'(i_time_word[14:12]) * 7'd10 + 7'(i_time_word[11:8]);
    assign n1_s   = 7'(i_time_word[6:4]) * 7'd10 + 7'(i_time_word[3:0]);
    assign n1_sat = (i_presc == '0) || ({1'b0, i_ssr} >= {i_presc, 1'b0});

    assign sub_prod = 28'(w_q[DIV_STAGES]) * 28'd1000;
    assign sub_raw  = sub_prod[27:16];
    assign n4_sub   = (r3_sat || (sub_raw > 12'(SUBSEC_LIMIT))) ? SUBSEC_LIMIT
                                                                : sub_raw[10:0];
    assign sum      = r4_t3 + 28'(r4_sub);

    always_ff @(posedge i_clk) begin
        r1_h      <= n1_h;
        r1_m      <= n1_m;
        r1_s      <= n1_s;
        r1_sat    <= n1_sat;
        r2_t1     <= 12'(r1_h) * 12'd60 + 12'(r1_m);
        r2_s      <= r1_s;
        r2_sat    <= r1_sat;
        r3_t2     <= 18'(r2_t1) * 18'd60 + 18'(r2_s);
        r3_sat    <= r2_sat;
        r4_t3     <= 28'(r3_t2) * 28'd1000;
        r4_sub    <= n4_sub;
        r5_millis <= (sum > 28'(MILLIS_MAX)) ? MILLIS_MAX : sum[MILLIS_W-1:0];
    end

    assign o_millis = r5_millis;

endmodule

@@ rtl/bcd_calendar_codec_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bcd_calendar_codec_core
// Converts between binary calendar fields and packed BCD time and date
// words, five-stage pipeline, one transaction per cycle.
//
// channel   dir  handshake                     payload
// command   in   i_start, taken when !o_busy   i_cmd, i_in_*, i_*_word_in, i_subsecond_count
// result    out  o_result_valid, one cycle     o_time_word_out, o_date_word_out, o_out_*
// config    in   i_sync_prescaler_wr_en        i_sync_prescaler
//
// result strobe comes out of five register stages, a depth set by the three-slice
// prescaler divider and the scale, add and saturate behind it
// a new transaction may be started every cycle, o_busy is always low
// synchronous active-low reset clears the valid pipeline and loads the
// prescaler with 256; no clearing pass
// the receiver cannot stall, so the pipeline never holds
// ============================================================================
module bcd_calendar_codec_core import bcc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_sync_prescaler_wr_en,
    input  logic [PRESC_W-1:0]  i_sync_prescaler,
    input  logic                i_cmd,
    input  logic [MILLIS_W-1:0] i_in_millis,
    input  logic [6:0]          i_in_year,
    input  logic [3:0]          i_in_month,
    input  logic [4:0]          i_in_day,
    input  logic [2:0]          i_in_weekday,
    input  logic [TWORD_W-1:0]  i_time_word_in,
    input  logic [DWORD_W-1:0]  i_date_word_in,
    input  logic [SSR_W-1:0]    i_subsecond_count,
    output logic                o_result_valid,
    output logic [TWORD_W-1:0]  o_time_word_out,
    output logic [DWORD_W-1:0]  o_date_word_out,
    output logic [MILLIS_W-1:0] o_out_millis,
    output logic [7:0]          o_out_year,
    output logic [4:0]          o_out_month,
    output logic [5:0]          o_out_day,
    output logic [2:0]          o_out_weekday
);

    logic [PRESC_W-1:0]  r_sync_prescaler;
    t_ctl                r_ctl  [1:PIPE_DEPTH];
    t_date_raw           r_date [1:PIPE_DEPTH-1];
    logic [DWORD_W-1:0]  r_date_word;
    logic [7:0]          r_year;
    logic [4:0]          r_month;
    logic [5:0]          r_day;
    logic [2:0]          r_weekday;
    logic [TWORD_W-1:0]  enc_time_word;
    logic [MILLIS_W-1:0] dec_millis;
    logic                is_enc;
    t_date_raw           d4;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_prescaler <= PRESC_RESET;
        end else if (i_sync_prescaler_wr_en) begin
            r_sync_prescaler <= i_sync_prescaler;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= PIPE_DEPTH; k++) begin
                r_ctl[k] <= '{vld: 1'b0, cmd: CMD_ENCODE};
            end
        end else begin
            r_ctl[1] <= '{vld: i_start && !o_busy, cmd: t_cmd'(i_cmd)};
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    assign d4 = r_date[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        r_date[1] <= '{year: i_in_year, month: i_in_month, day: i_in_day,
                       weekday: i_in_weekday, word: i_date_word_in};
        for (int k = 2; k <= PIPE_DEPTH - 1; k++) begin
            r_date[k] <= r_date[k-1];
        end
        r_date_word <= enc_date(d4.year, d4.month, d4.day, d4.weekday);
        r_year      <= 8'(d4.word[23:20]) * 8'd10 + 8'(d4.word[19:16]);
        r_month     <= 5'(d4.word[12]) * 5'd10 + 5'(d4.word[11:8]);
        r_day       <= 6'(d4.word[5:4]) * 6'd10 + 6'(d4.word[3:0]);
        r_weekday   <= d4.word[15:13];
    end

    bcc_time_enc u_time_enc (
        .i_clk       (i_clk),
        .i_millis    (i_in_millis),
        .o_time_word (enc_time_word)
    );

    bcc_time_dec u_time_dec (
        .i_clk       (i_clk),
        .i_time_word (i_time_word_in),
        .i_ssr       (i_subsecond_count),
        .i_presc     (r_sync_prescaler),
        .o_millis    (dec_millis)
    );

    assign is_enc          = (r_ctl[PIPE_DEPTH].cmd == CMD_ENCODE);
    assign o_result_valid  = r_ctl[PIPE_DEPTH].vld;
    assign o_time_word_out = is_enc ? enc_time_word : '0;
    assign o_date_word_out = is_enc ? r_date_word : '0;
    assign o_out_millis    = is_enc ? '0 : dec_millis;
    assign o_out_year      = is_enc ? '0 : r_year;
    assign o_out_month     = is_enc ? '0 : r_month;
    assign o_out_day       = is_enc ? '0 : r_day;
    assign o_out_weekday   = is_enc ? '0 : r_weekday;

    a_valid_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid == ($past(i_start, PIPE_DEPTH) && $past(i_rst_n, 5)
                           && $past(i_rst_n, 4) && $past(i_rst_n, 3)
                           && $past(i_rst_n, 2) && $past(i_rst_n, 1)))
        else $error("result strobe out of step with started transactions");

    a_cmd_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (r_ctl[PIPE_DEPTH].cmd == $past(i_cmd, PIPE_DEPTH)))
        else $error("result mode differs from started transaction");

    a_dec_zero_time : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !is_enc && ($past(i_time_word_in, PIPE_DEPTH) == '0))
        |-> (o_out_millis <= 27'd1000))
        else $error("subsecond contribution above limit");

    a_enc_sub_second : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && is_enc && ($past(i_in_millis, PIPE_DEPTH) < 27'd1000))
        |-> (o_time_word_out == '0))
        else $error("time word not zero below one second");

endmodule

@@ test/bcd_calendar_codec_core_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bcd_calendar_codec_core_checker
// Watches the command, configuration and result ports of the BCD calendar
// codec. Each accepted transaction is converted by an independent model
// that keeps its own copy of the prescaler register. The expected words
// are queued in order, and each result strobe is compared with the oldest
// entry, field by field. The outstanding count and the mismatch count are
// passed back to the testbench top.
// ============================================================================
module bcd_calendar_codec_core_checker import bcc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic                i_presc_wr_en,
    input  logic [PRESC_W-1:0]  i_presc,
    input  logic                i_cmd,
    input  logic [MILLIS_W-1:0] i_in_millis,
    input  logic [6:0]          i_in_year,
    input  logic [3:0]          i_in_month,
    input  logic [4:0]          i_in_day,
    input  logic [2:0]          i_in_weekday,
    input  logic [TWORD_W-1:0]  i_time_word_in,
    input  logic [DWORD_W-1:0]  i_date_word_in,
    input  logic [SSR_W-1:0]    i_subsecond_count,
    input  logic                i_result_valid,
    input  logic [TWORD_W-1:0]  i_time_word_out,
    input  logic [DWORD_W-1:0]  i_date_word_out,
    input  logic [MILLIS_W-1:0] i_out_millis,
    input  logic [7:0]          i_out_year,
    input  logic [4:0]          i_out_month,
    input  logic [5:0]          i_out_day,
    input  logic [2:0]          i_out_weekday,
    output logic [31:0]         o_pending,
    output logic [31:0]         o_mismatches
);

    typedef struct packed {
        logic [TWORD_W-1:0]  time_word;
        logic [DWORD_W-1:0]  date_word;
        logic [MILLIS_W-1:0] millis;
        logic [7:0]          year;
        logic [4:0]          month;
        logic [5:0]          day;
        logic [2:0]          weekday;
    } t_calendar_words;

    t_calendar_words    calendar_q[$];
    logic [PRESC_W-1:0] presc_copy = PRESC_RESET;
    int unsigned        mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [TWORD_W-1:0] bcd_time_of(input logic [MILLIS_W-1:0] ms);
        int unsigned        secs;
        logic [TWORD_W-1:0] w;
        secs     = ms / 1000;
        w        = '0;
        w[3:0]   = 4'(secs % 10);
        secs     = secs / 10;
        w[6:4]   = 3'(secs % 6);
        secs     = secs / 6;
        w[11:8]  = 4'(secs % 10);
        secs     = secs / 10;
        w[14:12] = 3'(secs % 6);
        secs     = secs / 6;
        w[19:16] = 4'(secs % 10);
        secs     = secs / 10;
        w[21:20] = 2'(secs);
        return w;
    endfunction

    function automatic logic [DWORD_W-1:0] bcd_date_of(
        input logic [6:0] year,
        input logic [3:0] month,
        input logic [4:0] day,
        input logic [2:0] weekday
    );
        int unsigned        y;
        int unsigned        m;
        int unsigned        d;
        logic [DWORD_W-1:0] w;
        y        = year;
        m        = month;
        d        = day;
        w        = '0;
        w[19:16] = 4'(y % 10);
        w[23:20] = 4'((y / 10) % 10);
        w[11:8]  = 4'(m % 10);
        w[12]    = 1'((m / 10) % 10);
        w[3:0]   = 4'(d % 10);
        w[5:4]   = 2'((d / 10) % 10);
        w[15:13] = weekday;
        return w;
    endfunction

    function automatic int unsigned millis_of_time(input logic [TWORD_W-1:0] tw);
        return tw[21:20] * 36000000 + tw[19:16] * 3600000 + tw[14:12] * 600000
             + tw[11:8] * 60000 + tw[6:4] * 10000 + tw[3:0] * 1000;
    endfunction

    function automatic longint unsigned subsec_millis(
        input logic [SSR_W-1:0]   ssr,
        input logic [PRESC_W-1:0] presc
    );
        longint unsigned q;
        longint unsigned s;
        if (presc == '0) begin
            return 1000;
        end
        q = ssr;
        q = (q << 16) / presc;
        s = (q * 1000) >> 16;
        if (s > 1000) begin
            s = 1000;
        end
        return s;
    endfunction

    function automatic t_calendar_words convert_calendar(
        input logic                cmd,
        input logic [MILLIS_W-1:0] millis,
        input logic [6:0]          year,
        input logic [3:0]          month,
        input logic [4:0]          day,
        input logic [2:0]          weekday,
        input logic [TWORD_W-1:0]  tw,
        input logic [DWORD_W-1:0]  dw,
        input logic [SSR_W-1:0]    ssr,
        input logic [PRESC_W-1:0]  presc
    );
        t_calendar_words r;
        longint unsigned ms;
        r = '0;
        if (t_cmd'(cmd) == CMD_ENCODE) begin
            r.time_word = bcd_time_of(millis);
            r.date_word = bcd_date_of(year, month, day, weekday);
        end else begin
            ms = millis_of_time(tw);
            ms = ms + subsec_millis(ssr, presc);
            if (ms > MILLIS_MAX) begin
                ms = MILLIS_MAX;
            end
            r.millis  = MILLIS_W'(ms);
            r.year    = 8'(dw[23:20] * 10 + dw[19:16]);
            r.month   = 5'(dw[12] * 10 + dw[11:8]);
            r.day     = 6'(dw[5:4] * 10 + dw[3:0]);
            r.weekday = dw[15:13];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s mismatch: got 0x%0h expected 0x%0h", what, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_calendar_words got;
        t_calendar_words want;
        if (!i_rst_n) begin
            calendar_q.delete();
            presc_copy = PRESC_RESET;
        end else begin
            if (i_result_valid) begin
                got = {i_time_word_out, i_date_word_out, i_out_millis, i_out_year,
                       i_out_month, i_out_day, i_out_weekday};
                if (calendar_q.size() == 0) begin
                    report_mismatch("result with no transaction outstanding");
                end else begin
                    want = calendar_q.pop_front();
                    compare_field("time word", 32'(got.time_word), 32'(want.time_word));
                    compare_field("date word", 32'(got.date_word), 32'(want.date_word));
                    compare_field("millis", 32'(got.millis), 32'(want.millis));
                    compare_field("year", 32'(got.year), 32'(want.year));
                    compare_field("month", 32'(got.month), 32'(want.month));
                    compare_field("day", 32'(got.day), 32'(want.day));
                    compare_field("weekday", 32'(got.weekday), 32'(want.weekday));
                end
            end
            if (i_start && !i_busy) begin
                calendar_q.push_back(convert_calendar(i_cmd, i_in_millis, i_in_year,
                    i_in_month, i_in_day, i_in_weekday, i_time_word_in, i_date_word_in,
                    i_subsecond_count, presc_copy));
            end
            if (i_presc_wr_en) begin
                presc_copy = i_presc;
            end
        end
        o_pending <= calendar_q.size();
    end

endmodule

@@ test/bcd_calendar_codec_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bcd_calendar_codec_core_tb
// Drives encode and decode transactions into the BCD calendar codec across
// several prescaler settings: the reset value, the extremes, zero and random
// values. A directed set covers field extremes, non-BCD digits and the
// saturation cases; random transactions follow, mostly well-formed BCD
// words, with bursts of idle cycles. The checker does the comparison.
// ============================================================================
module bcd_calendar_codec_core_tb;
    import bcc_pkg::*;

    typedef struct packed {
        t_cmd                cmd;
        logic [MILLIS_W-1:0] millis;
        logic [6:0]          year;
        logic [3:0]          month;
        logic [4:0]          day;
        logic [2:0]          weekday;
        logic [TWORD_W-1:0]  time_word;
        logic [DWORD_W-1:0]  date_word;
        logic [SSR_W-1:0]    ssr;
    } t_calendar_cmd;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic                i_sync_prescaler_wr_en = 1'b0;
    logic [PRESC_W-1:0]  i_sync_prescaler = PRESC_RESET;
    logic                i_cmd = 1'b0;
    logic [MILLIS_W-1:0] i_in_millis = '0;
    logic [6:0]          i_in_year = '0;
    logic [3:0]          i_in_month = '0;
    logic [4:0]          i_in_day = '0;
    logic [2:0]          i_in_weekday = '0;
    logic [TWORD_W-1:0]  i_time_word_in = '0;
    logic [DWORD_W-1:0]  i_date_word_in = '0;
    logic [SSR_W-1:0]    i_subsecond_count = '0;
    logic                o_busy;
    logic                o_result_valid;
    logic [TWORD_W-1:0]  o_time_word_out;
    logic [DWORD_W-1:0]  o_date_word_out;
    logic [MILLIS_W-1:0] o_out_millis;
    logic [7:0]          o_out_year;
    logic [4:0]          o_out_month;
    logic [5:0]          o_out_day;
    logic [2:0]          o_out_weekday;
    logic [31:0]         outstanding;
    logic [31:0]         mismatches;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    bcd_calendar_codec_core u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_start                (i_start),
        .o_busy                 (o_busy),
        .i_sync_prescaler_wr_en (i_sync_prescaler_wr_en),
        .i_sync_prescaler       (i_sync_prescaler),
        .i_cmd                  (i_cmd),
        .i_in_millis            (i_in_millis),
        .i_in_year              (i_in_year),
        .i_in_month             (i_in_month),
        .i_in_day               (i_in_day),
        .i_in_weekday           (i_in_weekday),
        .i_time_word_in         (i_time_word_in),
        .i_date_word_in         (i_date_word_in),
        .i_subsecond_count      (i_subsecond_count),
        .o_result_valid         (o_result_valid),
        .o_time_word_out        (o_time_word_out),
        .o_date_word_out        (o_date_word_out),
        .o_out_millis           (o_out_millis),
        .o_out_year             (o_out_year),
        .o_out_month            (o_out_month),
        .o_out_day              (o_out_day),
        .o_out_weekday          (o_out_weekday)
    );

    bcd_calendar_codec_core_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_busy            (o_busy),
        .i_presc_wr_en     (i_sync_prescaler_wr_en),
        .i_presc           (i_sync_prescaler),
        .i_cmd             (i_cmd),
        .i_in_millis       (i_in_millis),
        .i_in_year         (i_in_year),
        .i_in_month        (i_in_month),
        .i_in_day          (i_in_day),
        .i_in_weekday      (i_in_weekday),
        .i_time_word_in    (i_time_word_in),
        .i_date_word_in    (i_date_word_in),
        .i_subsecond_count (i_subsecond_count),
        .i_result_valid    (o_result_valid),
        .i_time_word_out   (o_time_word_out),
        .i_date_word_out   (o_date_word_out),
        .i_out_millis      (o_out_millis),
        .i_out_year        (o_out_year),
        .i_out_month       (o_out_month),
        .i_out_day         (o_out_day),
        .i_out_weekday     (o_out_weekday),
        .o_pending         (outstanding),
        .o_mismatches      (mismatches)
    );

    // unused side of each transaction carries random noise
    function automatic t_calendar_cmd noise_cmd();
        t_calendar_cmd c;
        c.cmd       = t_cmd'($urandom_range(0, 1));
        c.millis    = MILLIS_W'($urandom);
        c.year      = 7'($urandom);
        c.month     = 4'($urandom);
        c.day       = 5'($urandom);
        c.weekday   = 3'($urandom);
        c.time_word = TWORD_W'($urandom);
        c.date_word = DWORD_W'($urandom);
        c.ssr       = SSR_W'($urandom);
        return c;
    endfunction

    function automatic t_calendar_cmd encode_cmd(
        input int unsigned ms,
        input int unsigned year,
        input int unsigned month,
        input int unsigned day,
        input int unsigned weekday
    );
        t_calendar_cmd c;
        c         = noise_cmd();
        c.cmd     = CMD_ENCODE;
        c.millis  = MILLIS_W'(ms);
        c.year    = 7'(year);
        c.month   = 4'(month);
        c.day     = 5'(day);
        c.weekday = 3'(weekday);
        return c;
    endfunction

    function automatic t_calendar_cmd decode_cmd(
        input int unsigned tw,
        input int unsigned dw,
        input int unsigned ssr
    );
        t_calendar_cmd c;
        c           = noise_cmd();
        c.cmd       = CMD_DECODE;
        c.time_word = TWORD_W'(tw);
        c.date_word = DWORD_W'(dw);
        c.ssr       = SSR_W'(ssr);
        return c;
    endfunction

    function automatic t_calendar_cmd rand_calendar_cmd(input logic [PRESC_W-1:0] presc);
        t_calendar_cmd c;
        int unsigned   ht;
        int unsigned   mt;
        int unsigned   dt;
        c = noise_cmd();
        if ($urandom_range(0, 4) != 0) begin
            c.millis = MILLIS_W'($urandom_range(0, 86399999));
            c.year   = 7'($urandom_range(0, 99));
            c.month  = 4'($urandom_range(0, 12));
        end
        if ($urandom_range(0, 3) != 0) begin
            ht = $urandom_range(0, 2);
            mt = $urandom_range(0, 1);
            dt = $urandom_range(0, 3);
            c.time_word = {2'(ht), 4'(ht == 2 ? $urandom_range(0, 3) : $urandom_range(0, 9)),
                           1'b0, 3'($urandom_range(0, 5)), 4'($urandom_range(0, 9)),
                           1'b0, 3'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
            c.date_word = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)), 3'($urandom),
                           1'(mt), 4'(mt != 0 ? $urandom_range(0, 2) : $urandom_range(1, 9)),
                           2'b00, 2'(dt), 4'(dt == 3 ? $urandom_range(0, 1) : $urandom_range(0, 9))};
        end
        if (presc != '0 && $urandom_range(0, 3) != 0) begin
            c.ssr = SSR_W'($urandom_range(0, presc));
        end
        return c;
    endfunction

    task automatic issue_calendar(input t_calendar_cmd c, input bit idle_on);
        i_start           <= 1'b1;
        i_cmd             <= c.cmd;
        i_in_millis       <= c.millis;
        i_in_year         <= c.year;
        i_in_month        <= c.month;
        i_in_day          <= c.day;
        i_in_weekday      <= c.weekday;
        i_time_word_in    <= c.time_word;
        i_date_word_in    <= c.date_word;
        i_subsecond_count <= c.ssr;
        do @(posedge i_clk); while (o_busy);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (PIPE_DEPTH + 3) @(posedge i_clk);
    endtask

    task automatic stream_random(input int count, input bit idle_on);
        for (int i = 0; i < count; i++) begin
            issue_calendar(rand_calendar_cmd(i_sync_prescaler), idle_on);
        end
    endtask

    initial begin
        t_calendar_cmd      directed[$];
        logic [PRESC_W-1:0] presc;
        bit                 idle_on;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(encode_cmd(0, 0, 0, 0, 0));
        directed.push_back(encode_cmd(86399999, 99, 12, 31, 7));
        directed.push_back(encode_cmd(134217727, 127, 15, 31, 7));
        directed.push_back(encode_cmd(86400000, 100, 13, 30, 4));
        directed.push_back(encode_cmd(43200000, 45, 6, 15, 3));
        directed.push_back(encode_cmd(999, 9, 9, 9, 1));
        directed.push_back(encode_cmd(1000, 10, 10, 10, 2));
        directed.push_back(encode_cmd(59999, 19, 11, 19, 5));
        directed.push_back(encode_cmd(3599999, 20, 1, 20, 6));
        directed.push_back(encode_cmd(36000000, 90, 1, 29, 0));
        directed.push_back(decode_cmd(0, 0, 0));
        directed.push_back(decode_cmd(22'h235959, 24'h99F231, 255));
        directed.push_back(decode_cmd(22'h235959, 24'h000000, 256));
        directed.push_back(decode_cmd(22'h120000, 24'h451215, 65535));
        directed.push_back(decode_cmd(22'h3FFFFF, 24'hFFFFFF, 65535));
        directed.push_back(decode_cmd(22'h3FFFFF, 24'hFFFFFF, 0));
        directed.push_back(decode_cmd(22'h1F7F7F, 24'hAFEF3F, 128));
        directed.push_back(decode_cmd(22'h0A0A0A, 24'hF0A0FA, 1));
        directed.push_back(decode_cmd(22'h000001, 24'h00E001, 257));
        directed.push_back(decode_cmd(22'h2A0000, 24'h00C000, 32768));
        foreach (directed[k]) begin
            issue_calendar(directed[k], 1'b1);
        end

        // hold off until the pipeline is empty mid-stream
        stream_random(25, 1'b1);
        drain_results();
        stream_random(25, 1'b1);

        for (int ph = 1; ph <= 9; ph++) begin
            drain_results();
            case (ph)
                1:       presc = 16'd1;
                2:       presc = 16'd32768;
                3:       presc = 16'd0;
                4:       presc = 16'hFFFF;
                5:       presc = 16'd2;
                default: presc = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 32768))
                                                             : 16'($urandom_range(1, 64));
            endcase
            i_sync_prescaler_wr_en <= 1'b1;
            i_sync_prescaler       <= presc;
            @(posedge i_clk);
            i_sync_prescaler_wr_en <= 1'b0;
            idle_on = (ph != 9) && ($urandom_range(0, 3) != 0);
            stream_random(70, idle_on);
        end

        drain_results();
        if (mismatches == 0) begin
            $display("bcd_calendar_codec_core verification clean");
        end else begin
            $display("bcd_calendar_codec_core verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("bcd_calendar_codec_core verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bcc_pkg.sv
rtl/bcc_div_stage.sv
rtl/bcc_time_enc.sv
rtl/bcc_time_dec.sv
rtl/bcd_calendar_codec_core.sv
test/bcd_calendar_codec_core_checker.sv
test/bcd_calendar_codec_core_tb.sv
